FILE: rtl/isotp_rr_pkg.sv
// Shared types and constants for the ISO-TP response reassembler.
package isotp_rr_pkg;

  localparam int CNT_W         = 12;
  localparam int MSG_BYTES_DEF = 4096;

  localparam logic [7:0] PCI_TYPE_MASK = 8'hF0;
  localparam logic [7:0] PCI_CONSEC    = 8'h20;
  localparam logic [7:0] NRC_SID       = 8'h7F;
  localparam logic [7:0] NRC_PENDING   = 8'h78;
  localparam logic [7:0] SID_OFFSET    = 8'h40;
  localparam logic [2:0] LAST_OFF      = 3'd7;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_END  = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_POS        = 3'd1,
    ST_NEG        = 3'd2,
    ST_PEND       = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_READ       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    K_START  = 3'd0,
    K_SINGLE = 3'd1,
    K_FIRST  = 3'd2,
    K_CONSEC = 3'd3,
    K_STRAY  = 3'd4
  } kind_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [CNT_W-1:0] len;
    logic [7:0]       code;
  } res_t;

endpackage

FILE: rtl/isotp_rr_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface isotp_rr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic [11:0] read_index;
  modport source (output valid, op, data_byte, read_index, input ready);
  modport sink (input valid, op, data_byte, read_index, output ready);
endinterface

interface isotp_rr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] response_length;
  logic [7:0]  negative_code;
  logic [7:0]  read_byte;
  modport source (output valid, status, response_length, negative_code, read_byte,
                  input ready);
  modport sink (input valid, status, response_length, negative_code, read_byte,
                output ready);
endinterface

interface isotp_rr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] service_id;
  modport source (output valid, service_id, input ready);
  modport sink (input valid, service_id, output ready);
endinterface

FILE: rtl/isotp_rr_store.sv
// Message byte store: one write port, one registered read port.
module isotp_rr_store
  import isotp_rr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF,
  localparam int AW = $clog2(MSG_BYTES)
) (
  input  logic          clk,
  input  mem_wr_t       wr,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MSG_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/isotp_rr_parse.sv
// Frame parser and response classifier; drives store writes and result codes.
module isotp_rr_parse
  import isotp_rr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  input  logic [7:0] service_id,
  output mem_wr_t    wr,
  output res_t       res
);

  localparam logic [CNT_W:0] MSG_LIM = MSG_BYTES[CNT_W:0];

  kind_t            kind, kind_next;
  logic [2:0]       off, off_next;
  logic [2:0]       srem, srem_next;
  logic [CNT_W-1:0] tlen, tlen_next;
  logic [CNT_W-1:0] ccnt, ccnt_next;
  logic [3:0]       nseq, nseq_next;
  logic             awc, awc_next;
  logic [7:0]       h0, h0_next, h1, h1_next, h2, h2_next;
  logic             pend, pend_next;
  logic             dec, dec_next;
  status_t          o_status, o_status_next;
  logic [CNT_W-1:0] o_len, o_len_next;
  logic [7:0]       o_code, o_code_next;

  logic             take, do_store, do_done, first_len, bad_len;
  logic [CNT_W-1:0] cc_inc, cc_after, first_tl;
  logic [7:0]       hn0, hn1, hn2, req_sid;

  assign take      = accept && (op == OP_BYTE) && !dec;
  assign first_len = (kind == K_FIRST) && (off == 3'd1);
  assign do_store  = take && ((kind == K_SINGLE) ||
                     (((kind == K_FIRST && !first_len) || kind == K_CONSEC) && ccnt < tlen));
  assign cc_inc    = ccnt + 1'b1;
  assign cc_after  = do_store ? cc_inc : ccnt;
  assign first_tl  = {tlen[CNT_W-1:8], data_byte};
  assign bad_len   = (first_tl < CNT_W'(8)) || ({1'b0, first_tl} > MSG_LIM);
  assign req_sid   = service_id - SID_OFFSET;

  always_comb begin
    hn0 = h0;
    hn1 = h1;
    hn2 = h2;
    if (do_store) begin
      if (ccnt == CNT_W'(0)) hn0 = data_byte;
      if (ccnt == CNT_W'(1)) hn1 = data_byte;
      if (ccnt == CNT_W'(2)) hn2 = data_byte;
    end
  end

  always_comb begin
    wr.en   = do_store && ({1'b0, ccnt} < MSG_LIM);
    wr.addr = ccnt;
    wr.data = data_byte;
  end

  always_comb begin
    kind_next     = kind;
    off_next      = off;
    srem_next     = srem;
    tlen_next     = tlen;
    ccnt_next     = do_store ? cc_inc : ccnt;
    nseq_next     = nseq;
    awc_next      = awc;
    h0_next       = hn0;
    h1_next       = hn1;
    h2_next       = hn2;
    pend_next     = pend;
    dec_next      = dec;
    o_status_next = o_status;
    o_len_next    = o_len;
    o_code_next   = o_code;
    do_done       = 1'b0;

    if (take) begin
      unique case (kind)
        K_START: begin
          if (awc) begin
            if ((data_byte & PCI_TYPE_MASK) != PCI_CONSEC || data_byte[3:0] != nseq) begin
              dec_next      = 1'b1;
              o_status_next = ST_INCOMPLETE;
              o_len_next    = '0;
              o_code_next   = '0;
            end else begin
              kind_next = K_CONSEC;
              off_next  = 3'd1;
            end
          end else if (data_byte[7:4] == 4'h0) begin
            if (data_byte[3:0] == 4'h0 || data_byte[3]) begin
              dec_next      = 1'b1;
              o_status_next = ST_INCOMPLETE;
              o_len_next    = '0;
              o_code_next   = '0;
            end else begin
              kind_next = K_SINGLE;
              srem_next = data_byte[2:0];
              tlen_next = CNT_W'(data_byte[2:0]);
              ccnt_next = '0;
            end
          end else if (data_byte[7:4] == 4'h1) begin
            kind_next = K_FIRST;
            tlen_next = {data_byte[3:0], 8'h00};
            off_next  = 3'd1;
          end else begin
            kind_next = K_STRAY;
            off_next  = 3'd1;
          end
        end
        K_SINGLE: begin
          srem_next = srem - 1'b1;
          if (srem == 3'd1) begin
            kind_next = K_START;
            do_done   = 1'b1;
          end
        end
        K_FIRST: begin
          if (first_len) begin
            tlen_next = first_tl;
            if (bad_len) begin
              dec_next      = 1'b1;
              o_status_next = ST_INCOMPLETE;
              o_len_next    = '0;
              o_code_next   = '0;
            end else begin
              ccnt_next = '0;
              off_next  = off + 1'b1;
            end
          end else if (off == LAST_OFF) begin
            kind_next = K_START;
            off_next  = '0;
            awc_next  = 1'b1;
            nseq_next = 4'd1;
          end else begin
            off_next = off + 1'b1;
          end
        end
        K_CONSEC: begin
          if (off == LAST_OFF) begin
            kind_next = K_START;
            off_next  = '0;
            nseq_next = nseq + 1'b1;
            if (cc_after == tlen) begin
              awc_next = 1'b0;
              do_done  = 1'b1;
            end
          end else begin
            off_next = off + 1'b1;
          end
        end
        default: begin
          if (off == LAST_OFF) begin
            kind_next = K_START;
            off_next  = '0;
          end else begin
            off_next = off + 1'b1;
          end
        end
      endcase

      if (do_done) begin
        if (hn0 == NRC_SID && tlen_next >= CNT_W'(3)) begin
          if (hn1 == req_sid) begin
            if (hn2 == NRC_PENDING) begin
              pend_next = 1'b1;
            end else begin
              dec_next      = 1'b1;
              o_status_next = (hn2 == 8'h00) ? ST_NONE : ST_NEG;
              o_len_next    = '0;
              o_code_next   = hn2;
            end
          end
        end else if (hn0 == service_id) begin
          dec_next      = 1'b1;
          o_status_next = ST_POS;
          o_len_next    = tlen_next;
          o_code_next   = '0;
        end
      end
    end

    if (accept && op == OP_END) begin
      kind_next     = K_START;
      off_next      = '0;
      srem_next     = '0;
      tlen_next     = '0;
      ccnt_next     = '0;
      nseq_next     = 4'd1;
      awc_next      = 1'b0;
      h0_next       = '0;
      h1_next       = '0;
      h2_next       = '0;
      pend_next     = 1'b0;
      dec_next      = 1'b0;
      o_status_next = ST_NONE;
      o_len_next    = '0;
      o_code_next   = '0;
    end
  end

  always_comb begin
    res        = '0;
    res.status = ST_NONE;
    if (accept && op == OP_END) begin
      res.valid = 1'b1;
      if (dec) begin
        res.status = o_status;
        res.len    = o_len;
        res.code   = o_code;
      end else if (awc || kind == K_SINGLE || kind == K_FIRST || kind == K_CONSEC) begin
        res.status = ST_INCOMPLETE;
      end else begin
        res.status = pend ? ST_PEND : ST_NONE;
      end
    end
    if (accept && op == OP_READ) begin
      res.valid  = 1'b1;
      res.status = ST_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind     <= K_START;
      off      <= '0;
      srem     <= '0;
      tlen     <= '0;
      ccnt     <= '0;
      nseq     <= 4'd1;
      awc      <= 1'b0;
      h0       <= '0;
      h1       <= '0;
      h2       <= '0;
      pend     <= 1'b0;
      dec      <= 1'b0;
      o_status <= ST_NONE;
      o_len    <= '0;
      o_code   <= '0;
    end else begin
      kind     <= kind_next;
      off      <= off_next;
      srem     <= srem_next;
      tlen     <= tlen_next;
      ccnt     <= ccnt_next;
      nseq     <= nseq_next;
      awc      <= awc_next;
      h0       <= h0_next;
      h1       <= h1_next;
      h2       <= h2_next;
      pend     <= pend_next;
      dec      <= dec_next;
      o_status <= o_status_next;
      o_len    <= o_len_next;
      o_code   <= o_code_next;
    end
  end

endmodule

FILE: rtl/isotp_response_reassembler_top.sv
// Top level of the ISO-TP response reassembler.
//
//  channel  modport  payload                                           moves
//  cfg      sink     service_id                                        one register write
//  item     sink     op, data_byte, read_index                         one input item
//  result   source   status, response_length, negative_code, read_byte one result
//
// One item per cycle sustained unless results stall; a byte updates the parser, and
// a payload byte writes the store, in the cycle it is accepted. Results of end and read
// items pass through the read stage (store read) and then the output register.
// rst is synchronous; it clears parser, service_id and pipeline valids, not the store.
// A stalled result holds in the output register; bytes keep flowing and one more end
// or read item waits in the read stage before the input stalls.
module isotp_response_reassembler_top
  import isotp_rr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input logic                  clk,
  input logic                  rst,
  isotp_rr_cfg_if.sink         cfg,
  isotp_rr_in_if.sink          item,
  isotp_rr_out_if.source       result
);

  localparam int AW = $clog2(MSG_BYTES);
  localparam logic [CNT_W:0] MSG_LIM = MSG_BYTES[CNT_W:0];

  logic       [7:0] service_id;
  logic             in_acc, s1_adv, rd_en, rd_ok;
  mem_wr_t          mem_wr;
  res_t             res;
  logic       [7:0] rd_data;

  logic             s1_valid;
  status_t          s1_status;
  logic [CNT_W-1:0] s1_len;
  logic       [7:0] s1_code;
  logic             s1_rd_ok;

  logic             o_valid;
  status_t          o_status;
  logic [CNT_W-1:0] o_len;
  logic       [7:0] o_code;
  logic       [7:0] o_byte;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      service_id <= '0;
    end else if (cfg.valid) begin
      service_id <= cfg.service_id;
    end
  end

  assign s1_adv     = s1_valid && (!o_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign in_acc     = item.valid && item.ready;
  assign rd_ok      = {1'b0, item.read_index} < MSG_LIM;
  assign rd_en      = in_acc && item.op == OP_READ && rd_ok;

  isotp_rr_parse #(.MSG_BYTES(MSG_BYTES)) u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_acc),
    .op         (item.op),
    .data_byte  (item.data_byte),
    .service_id (service_id),
    .wr         (mem_wr),
    .res        (res)
  );

  isotp_rr_store #(.MSG_BYTES(MSG_BYTES)) u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (item.read_index[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= res.valid;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status <= res.status;
      s1_len    <= res.len;
      s1_code   <= res.code;
      s1_rd_ok  <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_status <= s1_status;
      o_len    <= s1_len;
      o_code   <= s1_code;
      o_byte   <= (s1_status == ST_READ && s1_rd_ok) ? rd_data : 8'h00;
    end
  end

  assign result.valid           = o_valid;
  assign result.status          = o_status;
  assign result.response_length = o_len;
  assign result.negative_code   = o_code;
  assign result.read_byte       = o_byte;

  a_wr_only_on_byte: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> item.valid && item.ready && item.op == OP_BYTE)
    else $error("store write without an accepted byte");

  a_byte_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_READ) |-> result.read_byte == 8'h00)
    else $error("read byte on a non-read result");

  a_len_only_on_pos: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_POS) |-> result.response_length == '0)
    else $error("length on a non-positive result");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    (in_acc && item.op == OP_READ) |=> s1_valid && s1_status == ST_READ)
    else $error("accepted read produced no result");

endmodule
